>>> src/lzss_decompressor_top_macros.svh
// Assertion macros used by the LZSS decompressor copy engine
`ifndef LZSS_DECOMPRESSOR_TOP_MACROS_SVH
`define LZSS_DECOMPRESSOR_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define LZSS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define LZSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lzss_pkg.sv
// Types and constants of the LZSS decompressor
`timescale 1ns / 1ps
package lzss_pkg;

    localparam int BYTE_W          = 8;
    localparam int POS_W           = 12;
    localparam int LEN_FIELD_W     = 4;
    localparam int TOKENS_W        = 4;
    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int MIN_MATCH_DEF   = 3;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [POS_W-1:0]    START_POS_RESET = 12'd4078;
    localparam logic [TOKENS_W-1:0] FLAG_BITS       = 4'd8;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              first_of_stream;
    } in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } out_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LITERAL,
        OP_MATCH
    } op_t;

    // One request from the parser to the copy engine
    typedef struct packed {
        logic                   clear;
        logic [POS_W-1:0]       start;
        op_t                    op;
        logic [BYTE_W-1:0]      data;
        logic [POS_W-1:0]       pos;
        logic [LEN_FIELD_W-1:0] len4;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LIT,
        BK_MREAD,
        BK_MCOPY
    } back_state_t;

endpackage

>>> src/lzss_decompressor_top.sv
// LZSS decompressor top level: config register, parser, queue, copy engine
//
//  port group  | direction | handshake          | payload
//  in_*        | input     | in_valid/in_stall   | in_t  (in_byte, first_of_stream)
//  out_*       | output    | out_valid/out_stall | out_t (out_byte, last_of_run)
//  cfg_*       | input     | cfg_valid/cfg_ready | 12-bit start_position
//
// Parser takes one byte per cycle while the two-entry request queue has room.
// Copy engine: literal via idle and literal states, match via idle, window read and copy states
// (one window byte per cycle unless out_stall holds it); flag and first match bytes start no copy.
// No clearing pass: a fill count marks bytes written since the stream start, the rest read 0.
// Reset is asynchronous, active low. out_stall holds the output register and backs up
// through the queue to in_stall.
`timescale 1ns / 1ps
module lzss_decompressor_top
    import lzss_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int MIN_MATCH   = MIN_MATCH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [POS_W-1:0] cfg_data
);

    logic [POS_W-1:0] start_pos_reg;
    logic             push, pop, fifo_empty, fifo_full;
    cmd_t             push_data, head;

    assign cfg_ready = 1'b1;
    assign in_stall  = fifo_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_pos_reg <= START_POS_RESET;
        else if (cfg_valid && cfg_ready)
            start_pos_reg <= cfg_data;
    end

    lzss_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .start_position (start_pos_reg),
        .push           (push),
        .push_data      (push_data)
    );

    lzss_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    lzss_back #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .MIN_MATCH   (MIN_MATCH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

>>> src/lzss_ram.sv
// Generic single-write, single-read RAM with registered, write-first read
`timescale 1ns / 1ps
module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lzss_fifo.sv
// Small request queue between the token parser and the copy engine
`timescale 1ns / 1ps
module lzss_fifo
    import lzss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF  // at least 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

endmodule

>>> src/lzss_front.sv
// Token parser: flag bytes, literals and two-byte match references
`timescale 1ns / 1ps
module lzss_front
    import lzss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  in_t              in_data,
    input  logic [POS_W-1:0] start_position,
    output logic             push,
    output cmd_t             push_data
);

    logic [BYTE_W-1:0]   flags_reg, flags_next;
    logic [TOKENS_W-1:0] left_reg, left_next;
    logic                await_reg, await_next;
    logic [BYTE_W-1:0]   fmb_reg, fmb_next;

    logic                accept;
    logic [BYTE_W-1:0]   flags_cur;
    logic [TOKENS_W-1:0] left_cur;
    logic                await_cur;
    logic [BYTE_W-1:0]   b;

    assign accept = in_valid && !in_stall;
    assign b      = in_data.in_byte;

    always_comb
    begin
        // a stream mark resets token state before the byte is parsed
        flags_cur = in_data.first_of_stream ? '0 : flags_reg;
        left_cur  = in_data.first_of_stream ? '0 : left_reg;
        await_cur = in_data.first_of_stream ? 1'b0 : await_reg;

        flags_next = flags_cur;
        left_next  = left_cur;
        await_next = await_cur;
        fmb_next   = fmb_reg;

        push_data       = '0;
        push_data.clear = in_data.first_of_stream;
        push_data.start = start_position;
        push_data.op    = OP_NONE;
        push_data.data  = b;

        if (await_cur)
        begin
            push_data.op   = OP_MATCH;
            push_data.pos  = {b[7:4], fmb_reg};
            push_data.len4 = b[3:0];
            left_next      = left_cur - 1'b1;
            await_next     = 1'b0;
        end
        else if (left_cur == '0)
        begin
            flags_next = b;
            left_next  = FLAG_BITS;
        end
        else
        begin
            flags_next = flags_cur >> 1;
            if (flags_cur[0])
            begin
                push_data.op = OP_LITERAL;
                left_next    = left_cur - 1'b1;
            end
            else
            begin
                fmb_next   = b;
                await_next = 1'b1;
            end
        end

        push = accept && (in_data.first_of_stream || (push_data.op != OP_NONE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            left_reg  <= '0;
            await_reg <= 1'b0;
        end
        else if (accept)
        begin
            flags_reg <= flags_next;
            left_reg  <= left_next;
            await_reg <= await_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fmb_reg <= fmb_next;
        end
    end

endmodule

>>> src/lzss_back.sv
// Copy engine: window writes, match reads and the output register
`timescale 1ns / 1ps
`include "lzss_decompressor_top_macros.svh"
module lzss_back
    import lzss_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,  // power of two
    parameter int MIN_MATCH   = MIN_MATCH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  cmd_t head,
    input  logic fifo_empty,
    output logic pop,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int FW = AW + 1;
    localparam int LW = $clog2((1 << LEN_FIELD_W) + MIN_MATCH);

    back_state_t      state_reg, state_next;

    logic [AW-1:0]     wp_reg;
    logic [AW-1:0]     stream_reg;
    logic [FW-1:0]     fill_reg;
    logic [AW-1:0]     src_reg;
    logic [LW-1:0]     cnt_reg;
    logic [LW-1:0]     len_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              rd_valid_reg;
    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg;

    logic              advance;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata, copy_byte;
    logic              load, load_last;
    logic              copy_last;
    logic [AW-1:0]     rd_offset;
    logic [FW-1:0]     fill_inc, fill_eff;
    logic              rd_valid_next;

    lzss_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign advance   = !out_valid_reg || !out_stall;
    assign copy_byte = rd_valid_reg ? ram_rdata : '0;
    assign copy_last = (cnt_reg == len_reg - 1'b1);
    assign fill_inc  = (fill_reg == FW'(WINDOW_SIZE)) ? fill_reg : fill_reg + 1'b1;

    // Entries outside the arc written since the stream start still read as zero
    always_comb
    begin
        fill_eff      = ram_we ? fill_inc : fill_reg;
        rd_offset     = ram_raddr - stream_reg;
        rd_valid_next = ({1'b0, rd_offset} < fill_eff);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    if (head.op == OP_LITERAL)
                        state_next = BK_LIT;
                    else if (head.op == OP_MATCH)
                        state_next = BK_MREAD;
                end
            end
            BK_LIT:
            begin
                if (advance)
                    state_next = BK_IDLE;
            end
            BK_MREAD:
            begin
                state_next = BK_MCOPY;
            end
            BK_MCOPY:
            begin
                if (advance && copy_last)
                    state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = src_reg;
        ram_wdata = byte_reg;
        load      = 1'b0;
        load_last = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop = !fifo_empty;
            end
            BK_LIT:
            begin
                ram_we    = advance;
                load      = advance;
                load_last = 1'b1;
            end
            BK_MREAD:
            begin
                ram_re = 1'b1;
            end
            BK_MCOPY:
            begin
                ram_wdata = copy_byte;
                ram_we    = advance;
                load      = advance;
                load_last = copy_last;
                // next read may hit the byte written this cycle; RAM forwards it
                ram_re    = advance && !copy_last;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            wp_reg        <= START_POS_RESET[AW-1:0];
            stream_reg    <= START_POS_RESET[AW-1:0];
            fill_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (pop && head.clear)
            begin
                wp_reg     <= head.start[AW-1:0];
                stream_reg <= head.start[AW-1:0];
                fill_reg   <= '0;
            end
            else if (ram_we)
            begin
                wp_reg   <= wp_reg + 1'b1;
                fill_reg <= fill_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg <= head.data;
            src_reg  <= head.pos[AW-1:0];
            len_reg  <= LW'(head.len4) + LW'(MIN_MATCH);
            cnt_reg  <= '0;
        end
        else
        begin
            if (ram_re)
            begin
                src_reg      <= src_reg + 1'b1;
                rd_valid_reg <= rd_valid_next;
            end
            if (state_reg == BK_MCOPY && advance)
                cnt_reg <= cnt_reg + 1'b1;
        end
        if (load)
        begin
            out_data_reg.out_byte    <= ram_wdata;
            out_data_reg.last_of_run <= load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `LZSS_ASSERT(a_fill_bound, 1'b1, fill_reg <= FW'(WINDOW_SIZE), "fill count past window size")
    `LZSS_ASSERT(a_copy_count, state_reg == BK_MCOPY, cnt_reg < len_reg, "copy ran past match length")
    `LZSS_ASSERT(a_write_emits, ram_we, load, "window write without an output byte")
    `LZSS_ASSERT_NEXT(a_op_starts, pop && head.op != OP_NONE, state_reg != BK_IDLE, "request not started")

endmodule

>>> tb/lzss_decompressor_top_test.sv
// Self-checking testbench for the LZSS decompressor top level
`timescale 1ns / 1ps
module lzss_decompressor_top_test;
    import lzss_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 150;
    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASE_ITEMS   = 50;
    localparam int NUM_PHASES    = 5;
    localparam int BY_MODEL      = -1;
    localparam int WIN_DEPTH     = 1 << POS_W;

    typedef struct packed {
        in_t              item;
        logic             typed;
        logic [4:0]       n_out;
        logic [BYTE_W-1:0] val;
    } script_row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_t              in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_t             out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [POS_W-1:0] cfg_data  = '0;

    // decoder copy: window, write pointer, token state, start register
    logic [BYTE_W-1:0]   hist_win [0:WIN_DEPTH-1];
    logic [POS_W-1:0]    wr_pos;
    logic [BYTE_W-1:0]   flag_bits;
    logic [TOKENS_W-1:0] tok_left;
    logic [BYTE_W-1:0]   match_lo;
    logic                want_hi;
    logic [POS_W-1:0]    start_pos_cfg;

    out_t        step_bytes[$];
    out_t        expected_bytes[$];
    script_row_t script[$];

    int in_taken   = 0;
    int items_sent = 0;
    int mismatches = 0;
    int quiet      = 0;
    bit calm       = 1'b0;
    bit want_hold  = 1'b0;
    bit hold_done  = 1'b0;

    lzss_decompressor_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void open_stream();
        for (int i = 0; i < WIN_DEPTH; i++)
            hist_win[i] = '0;
        wr_pos    = start_pos_cfg;
        flag_bits = '0;
        tok_left  = '0;
        match_lo  = '0;
        want_hi   = 1'b0;
    endfunction

    function automatic void emit(logic [BYTE_W-1:0] v);
        out_t r;
        hist_win[wr_pos] = v;
        wr_pos           = wr_pos + 1'b1;
        r.out_byte       = v;
        r.last_of_run    = 1'b0;
        step_bytes       = {step_bytes, r};
    endfunction

    // decoded bytes caused by one compressed byte, left in step_bytes
    function automatic void decode_step(in_t item);
        logic [POS_W-1:0]  src;
        logic [POS_W-1:0]  rd;
        logic [BYTE_W-1:0] v;
        int                run_len;
        out_t              r;
        step_bytes.delete();
        if (item.first_of_stream)
            open_stream();
        if (want_hi)
        begin
            src     = {item.in_byte[7:4], match_lo};
            run_len = item.in_byte[3:0] + MIN_MATCH_DEF;
            // read before write, so overlapping copies see fresh bytes
            for (int i = 0; i < run_len; i++)
            begin
                rd = src + POS_W'(i);
                v  = hist_win[rd];
                emit(v);
            end
            want_hi  = 1'b0;
            tok_left = tok_left - 1'b1;
        end
        else if (tok_left == 0)
        begin
            flag_bits = item.in_byte;
            tok_left  = FLAG_BITS;
        end
        else if (flag_bits[0])
        begin
            flag_bits = flag_bits >> 1;
            emit(item.in_byte);
            tok_left  = tok_left - 1'b1;
        end
        else
        begin
            flag_bits = flag_bits >> 1;
            match_lo  = item.in_byte;
            want_hi   = 1'b1;
        end
        if (step_bytes.size() > 0)
        begin
            r             = step_bytes[step_bytes.size() - 1];
            r.last_of_run = 1'b1;
            step_bytes[step_bytes.size() - 1] = r;
        end
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatches < 200)
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void add_row(logic [BYTE_W-1:0] b, logic fos, int n,
                                    logic [BYTE_W-1:0] v);
        script_row_t r;
        r.item.in_byte         = b;
        r.item.first_of_stream = fos;
        r.typed                = (n >= 0);
        r.n_out                = 5'((n >= 0) ? n : 0);
        r.val                  = v;
        script                 = {script, r};
    endfunction

    // predictor, scoreboard and watchdog
    always @(posedge clk)
    begin
        out_t want;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                start_pos_cfg = cfg_data;
                moved         = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (expected_bytes.size() == 0)
                begin
                    flag_mismatch("result with nothing pending", out_data.out_byte, 0);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_data.out_byte !== want.out_byte)
                        flag_mismatch("out_byte", out_data.out_byte, want.out_byte);
                    if (out_data.last_of_run !== want.last_of_run)
                        flag_mismatch("last_of_run", out_data.last_of_run, want.last_of_run);
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                decode_step(in_data);
                if (in_taken < script.size() && script[in_taken].typed)
                begin
                    for (int j = 0; j < script[in_taken].n_out; j++)
                    begin
                        want.out_byte    = script[in_taken].val;
                        want.last_of_run = (j == script[in_taken].n_out - 1);
                        expected_bytes   = {expected_bytes, want};
                    end
                end
                else
                begin
                    foreach (step_bytes[j])
                        expected_bytes = {expected_bytes, step_bytes[j]};
                end
                in_taken++;
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // receiver: short stall bursts, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (want_hold && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // valid stays high after the request unless a gap follows
    task automatic send_byte(logic [BYTE_W-1:0] b, logic fos);
        in_valid                <= 1'b1;
        in_data.in_byte         <= b;
        in_data.first_of_stream <= fos;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_start(logic [POS_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // well-formed stream; matches mostly point a short way back for overlap
    task automatic send_stream(int groups, bit cut);
        logic [BYTE_W-1:0] flags;
        logic [POS_W-1:0]  est_pos;
        logic [POS_W-1:0]  src;
        logic [3:0]        len4;
        int                ntok;
        est_pos = start_pos_cfg;
        for (int g = 0; g < groups; g++)
        begin
            flags = BYTE_W'($urandom_range(0, 255));
            send_byte(flags, g == 0);
            ntok = (g == groups - 1 && !cut) ? $urandom_range(1, 8) : 8;
            for (int k = 0; k < ntok; k++)
            begin
                if (flags[k])
                begin
                    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
                    est_pos = est_pos + 1'b1;
                end
                else
                begin
                    len4 = 4'($urandom_range(0, 15));
                    if ($urandom_range(0, 3) != 0)
                        src = est_pos - POS_W'($urandom_range(1, 24));
                    else
                        src = POS_W'($urandom_range(0, WIN_DEPTH - 1));
                    send_byte(src[7:0], 1'b0);
                    send_byte({src[11:8], len4}, 1'b0);
                    est_pos = est_pos + POS_W'(len4) + POS_W'(MIN_MATCH_DEF);
                end
            end
        end
        // stream ends after the first match byte
        if (cut)
        begin
            send_byte(8'h00, 1'b0);
            send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic send_noise(int n);
        for (int i = 0; i < n; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    endtask

    initial
    begin
        int  goal;
        bit  paused;
        start_pos_cfg = START_POS_RESET;
        open_stream();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no stream mark yet: decodes against the reset state
        add_row(8'h01, 1'b0, 0, 8'h00);
        add_row(8'hFF, 1'b0, 1, 8'hFF);
        add_row(8'h00, 1'b0, 0, 8'h00);
        add_row(8'h0F, 1'b0, 18, 8'h00);
        // two literals, then an overlapping copy, a copy across the wrap and one more copy
        add_row(8'h03, 1'b1, 0, 8'h00);
        add_row(8'hA5, 1'b0, 1, 8'hA5);
        add_row(8'h5A, 1'b0, 1, 8'h5A);
        add_row(8'hEE, 1'b0, 0, 8'h00);
        add_row(8'hF0, 1'b0, BY_MODEL, 8'h00);
        add_row(8'hFF, 1'b0, 0, 8'h00);
        add_row(8'hFF, 1'b0, BY_MODEL, 8'h00);
        add_row(8'h00, 1'b0, 0, 8'h00);
        add_row(8'h00, 1'b0, BY_MODEL, 8'h00);
        // first match byte, then a new stream drops it
        add_row(8'h34, 1'b0, 0, 8'h00);
        add_row(8'hFF, 1'b1, 0, 8'h00);
        add_row(8'h00, 1'b0, 1, 8'h00);
        add_row(8'h80, 1'b0, 1, 8'h80);
        add_row(8'h7F, 1'b0, 1, 8'h7F);
        // all-match flag on a cleared window
        add_row(8'h00, 1'b1, 0, 8'h00);
        add_row(8'hED, 1'b0, 0, 8'h00);
        add_row(8'hF1, 1'b0, 4, 8'h00);
        add_row(8'h10, 1'b0, 0, 8'h00);
        add_row(8'h00, 1'b0, BY_MODEL, 8'h00);
        foreach (script[i])
            send_byte(script[i].item.in_byte, script[i].item.first_of_stream);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       write_start('0);
                1:       write_start('1);
                default: write_start(POS_W'($urandom_range(0, WIN_DEPTH - 1)));
            endcase
            if (ph == NUM_PHASES - 1)
                calm = 1'b1;
            goal   = items_sent + PHASE_ITEMS;
            paused = 1'b0;
            while (items_sent < goal)
            begin
                if (ph == 0 && items_sent > goal - 45)
                    want_hold = 1'b1;
                if (ph == 1 && !paused && items_sent > goal - 30)
                begin
                    drain();
                    paused = 1'b1;
                end
                if (ph == 2 && $urandom_range(0, 2) == 0)
                    send_noise($urandom_range(4, 12));
                else
                    send_stream($urandom_range(1, 3), $urandom_range(0, 4) == 0);
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
